// File: hdl/pwmps_pkg.sv
// Shared types, constants and prescaler tables of the PWM prescaler and TOP solver.
package pwmps_pkg;

   // Field widths
   localparam int CLK_W      = 26;
   localparam int FREQ_W     = 24;
   localparam int DUTY_W     = 8;
   localparam int CHAN_W     = 3;
   localparam int ST_W       = 2;
   localparam int SEL_W      = 3;
   localparam int TOP_W      = 16;
   localparam int SHIFT_W    = 4;
   localparam int IDX_W      = 3;
   // Divisor is freq shifted left by up to ten bits
   localparam int DIVR_W     = FREQ_W + 10;
   // TOP + 1 fits in 17 bits, duty * (TOP + 1) in 25 bits
   localparam int TOPP1_W    = TOP_W + 1;
   localparam int PROD_W     = DUTY_W + TOPP1_W;
   localparam int CNT_W      = 5;

   // Stream and register port widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int CHANNEL_COUNT = 6;

   localparam logic [CLK_W-1:0]  CLOCK_RESET = 26'd16000000;
   localparam logic [DUTY_W-1:0] DUTY_MAX    = 8'd100;
   localparam logic [DIVR_W-1:0] PERCENT_DIV = 34'd100;

   typedef enum logic [ST_W-1:0] {
      ST_OK          = 2'd0,
      ST_BAD_CHANNEL = 2'd1,
      ST_BAD_DUTY    = 2'd2,
      ST_BAD_FREQ    = 2'd3
   } status_type;

   // Timer groups: 8-bit short table, 16-bit short table, 8-bit long table
   typedef enum logic [1:0] {
      GRP_SHORT8,
      GRP_SHORT16,
      GRP_LONG8
   } group_type;

   // Request to the shared divider
   typedef struct packed {
      logic              start;
      logic [CLK_W-1:0]  dividend;
      logic [DIVR_W-1:0] divisor;
   } div_req_type;

   // Answer from the shared divider
   typedef struct packed {
      logic             done;
      logic [CLK_W-1:0] quotient;
   } div_rsp_type;

   // Prescalers are powers of two; table gives log2 of each entry
   function automatic logic [SHIFT_W-1:0] presc_shift(group_type grp,
                                                      logic [IDX_W-1:0] idx);
      logic [SHIFT_W-1:0] sh;
      sh = '0;
      if (grp == GRP_LONG8) begin
         case (idx)
            3'd0:    sh = 4'd0;
            3'd1:    sh = 4'd3;
            3'd2:    sh = 4'd5;
            3'd3:    sh = 4'd6;
            3'd4:    sh = 4'd7;
            3'd5:    sh = 4'd8;
            3'd6:    sh = 4'd10;
            default: sh = 4'd10;
         endcase
      end else begin
         case (idx)
            3'd0:    sh = 4'd0;
            3'd1:    sh = 4'd3;
            3'd2:    sh = 4'd6;
            3'd3:    sh = 4'd8;
            default: sh = 4'd10;
         endcase
      end
      return sh;
   endfunction

   // Index of the last prescaler in the group's table
   function automatic logic [IDX_W-1:0] presc_last(group_type grp);
      return (grp == GRP_LONG8) ? 3'd6 : 3'd4;
   endfunction

   // Largest quotient that still fits: TOP limit plus one
   function automatic logic [TOPP1_W-1:0] fit_bound(group_type grp);
      return (grp == GRP_SHORT16) ? 17'd65536 : 17'd256;
   endfunction

endpackage

// File: hdl/pwmps_div.sv
// Shared restoring divider, one quotient bit per cycle.
module pwmps_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pwmps_pkg::div_req_type div_req,
   output pwmps_pkg::div_rsp_type div_rsp
);

   localparam int CW = pwmps_pkg::CLK_W;
   localparam int DW = pwmps_pkg::DIVR_W;
   localparam int NW = pwmps_pkg::CNT_W;

   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] quo_ff, quo_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;

   logic [CW:0]   shifted;
   logic [DW-1:0] shifted_ext;
   logic [DW-1:0] diff;
   logic          take;

   // One step: shift next dividend bit in, subtract when it fits
   always_comb begin
      shifted     = {rem_ff, quo_ff[CW-1]};
      shifted_ext = {{(DW-CW-1){1'b0}}, shifted};
      take        = (shifted_ext >= dvs_ff);
      diff        = shifted_ext - dvs_ff;
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in = '0;
         quo_in = div_req.dividend;
         dvs_in = div_req.divisor;
         cnt_in = NW'(CW);
      end else if (cnt_ff != '0) begin
         // remainder stays below the partial dividend, so CW bits hold it
         rem_in  = take ? diff[CW-1:0] : shifted[CW-1:0];
         quo_in  = {quo_ff[CW-2:0], take};
         cnt_in  = cnt_ff - NW'(1);
         done_in = (cnt_ff == NW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// File: hdl/pwmps_csr.sv
// APB register block holding the timer input clock frequency.
module pwmps_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pwmps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pwmps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pwmps_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready,
   output logic [pwmps_pkg::CLK_W-1:0]      clock_hz
);

   localparam int AW = pwmps_pkg::CSR_ADDR_W;
   localparam int DW = pwmps_pkg::CSR_DATA_W;
   localparam int CW = pwmps_pkg::CLK_W;

   localparam logic [AW-3:0] REG_CLOCK_HZ = '0;

   logic [CW-1:0] clock_hz_ff, clock_hz_in;
   logic [AW-3:0] reg_idx;
   logic          wr_beat;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[AW-1:2];
   assign wr_beat    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Write decode; other addresses are ignored
   always_comb begin
      clock_hz_in = clock_hz_ff;
      if (wr_beat && (reg_idx == REG_CLOCK_HZ)) begin
         clock_hz_in = csr_pwdata[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= pwmps_pkg::CLOCK_RESET;
      end else begin
         clock_hz_ff <= clock_hz_in;
      end
   end

   // Read decode
   always_comb begin
      unique case (reg_idx)
         REG_CLOCK_HZ: csr_prdata = {{(DW-CW){1'b0}}, clock_hz_ff};
         default:      csr_prdata = '0;
      endcase
   end

   assign clock_hz = clock_hz_ff;

endmodule

// File: hdl/pwm_prescaler_top_duty_solver.sv
// Top level: request checks, prescaler walk sequencer, duty compare and result register.
//
//   channel   dir  handshake              payload
//   req_      in   req_tvalid/req_tready  channel, freq_hz, duty_percent
//   rsp_      out  rsp_tvalid/rsp_tready  status, clock_select, top_value, compare_value
//   csr_      in   APB, pready tied high  clock_hz at byte address 0
//
// An accepted request runs one divide on the shared 26-step restoring divider per
// prescaler tried, then the duty multiply and the divide by 100. A request rejected
// on channel, duty or zero frequency skips the divider. Reset is synchronous, clears
// the sequencer and the result valid, and sets the register to 16000000 Hz. A waiting
// result holds the sequencer in its last state.
module pwm_prescaler_top_duty_solver (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [2:0] channel, [26:3] freq_hz, [34:27] duty_percent, [39:35] zero
   input  logic [pwmps_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] status, [4:2] clock_select, [20:5] top_value, [36:21] compare_value,
   // [39:37] zero
   output logic [pwmps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pwmps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pwmps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pwmps_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);

   localparam int CW  = pwmps_pkg::CLK_W;
   localparam int FW  = pwmps_pkg::FREQ_W;
   localparam int DYW = pwmps_pkg::DUTY_W;
   localparam int HW  = pwmps_pkg::CHAN_W;
   localparam int SLW = pwmps_pkg::SEL_W;
   localparam int TW  = pwmps_pkg::TOP_W;
   localparam int T1W = pwmps_pkg::TOPP1_W;
   localparam int PW  = pwmps_pkg::PROD_W;
   localparam int IW  = pwmps_pkg::IDX_W;
   localparam int VW  = pwmps_pkg::DIVR_W;
   localparam int SW  = pwmps_pkg::ST_W;
   localparam int RDW = pwmps_pkg::RSP_DATA_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_WAIT,
      S_MUL,
      S_CMP_START,
      S_CMP_WAIT,
      S_DONE
   } state_type;

   logic [CW-1:0]          clock_hz;
   pwmps_pkg::div_req_type div_req;
   pwmps_pkg::div_rsp_type div_rsp;

   state_type              state_ff, state_in;
   pwmps_pkg::group_type   grp_ff, grp_in;
   logic [FW-1:0]          freq_ff, freq_in;
   logic [DYW-1:0]         duty_ff, duty_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic [T1W-1:0]         topp1_ff, topp1_in;
   logic [SLW-1:0]         sel_ff, sel_in;
   logic [PW-1:0]          prod_ff, prod_in;
   pwmps_pkg::status_type  st_ff, st_in;
   logic [TW-1:0]          cmp_ff, cmp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RDW-1:0]         rsp_data_ff, rsp_data_in;

   logic [HW-1:0]          req_chan;
   logic [FW-1:0]          req_freq;
   logic [DYW-1:0]         req_duty;
   logic                   req_beat;
   logic [CW-1:0]          quo;
   logic                   fits;
   logic                   out_free;

   pwmps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .clock_hz    (clock_hz)
   );

   pwmps_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_chan   = req_tdata[HW-1:0];
   assign req_freq   = req_tdata[HW+FW-1:HW];
   assign req_duty   = req_tdata[HW+FW+DYW-1:HW+FW];
   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Divider operands: clock / (prescaler * freq) while scanning, product / 100 after
   always_comb begin
      div_req.start = (state_ff == S_SCAN) || (state_ff == S_CMP_START);
      if (state_ff == S_CMP_START) begin
         div_req.dividend = {{(CW-PW){1'b0}}, prod_ff};
         div_req.divisor  = pwmps_pkg::PERCENT_DIV;
      end else begin
         div_req.dividend = clock_hz;
         div_req.divisor  = {{(VW-FW){1'b0}}, freq_ff}
                            << pwmps_pkg::presc_shift(grp_ff, idx_ff);
      end
   end

   // Nonzero quotient within the group's TOP limit plus one
   assign quo  = div_rsp.quotient;
   assign fits = (quo != '0) && (quo <= {{(CW-T1W){1'b0}}, pwmps_pkg::fit_bound(grp_ff)});

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      grp_in       = grp_ff;
      freq_in      = freq_ff;
      duty_in      = duty_ff;
      idx_in       = idx_ff;
      topp1_in     = topp1_ff;
      sel_in       = sel_ff;
      prod_in      = prod_ff;
      st_in        = st_ff;
      cmp_in       = cmp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               freq_in = req_freq;
               duty_in = req_duty;
               idx_in  = '0;
               if (req_chan <= HW'(1)) begin
                  grp_in = pwmps_pkg::GRP_SHORT8;
               end else if (req_chan <= HW'(3)) begin
                  grp_in = pwmps_pkg::GRP_SHORT16;
               end else begin
                  grp_in = pwmps_pkg::GRP_LONG8;
               end
               // checks in order: channel, duty, frequency
               if (req_chan >= HW'(pwmps_pkg::CHANNEL_COUNT)) begin
                  st_in    = pwmps_pkg::ST_BAD_CHANNEL;
                  state_in = S_DONE;
               end else if (req_duty > pwmps_pkg::DUTY_MAX) begin
                  st_in    = pwmps_pkg::ST_BAD_DUTY;
                  state_in = S_DONE;
               end else if (req_freq == '0) begin
                  st_in    = pwmps_pkg::ST_BAD_FREQ;
                  state_in = S_DONE;
               end else begin
                  st_in    = pwmps_pkg::ST_OK;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            state_in = S_SCAN_WAIT;
         end
         S_SCAN_WAIT: begin
            if (div_rsp.done) begin
               if (fits) begin
                  topp1_in = quo[T1W-1:0];
                  sel_in   = SLW'(idx_ff) + SLW'(1);
                  if (quo == CW'(1)) begin
                     // first fit gives TOP of zero
                     st_in    = pwmps_pkg::ST_BAD_FREQ;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_MUL;
                  end
               end else if (idx_ff == pwmps_pkg::presc_last(grp_ff)) begin
                  st_in    = pwmps_pkg::ST_BAD_FREQ;
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = S_SCAN;
               end
            end
         end
         S_MUL: begin
            prod_in  = PW'(duty_ff) * PW'(topp1_ff);
            state_in = S_CMP_START;
         end
         S_CMP_START: begin
            state_in = S_CMP_WAIT;
         end
         S_CMP_WAIT: begin
            if (div_rsp.done) begin
               cmp_in   = (quo == '0) ? '0 : TW'(quo[T1W-1:0] - T1W'(1));
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (st_ff == pwmps_pkg::ST_OK) begin
                  rsp_data_in = {{(RDW-SW-SLW-2*TW){1'b0}}, cmp_ff,
                                 TW'(topp1_ff - T1W'(1)), sel_ff, SW'(st_ff)};
               end else begin
                  rsp_data_in = {{(RDW-SW){1'b0}}, SW'(st_ff)};
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      grp_ff      <= grp_in;
      freq_ff     <= freq_in;
      duty_ff     <= duty_in;
      idx_ff      <= idx_in;
      topp1_ff    <= topp1_in;
      sel_ff      <= sel_in;
      prod_ff     <= prod_in;
      st_ff       <= st_in;
      cmp_ff      <= cmp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: test/tb_pwm_prescaler_top_duty_solver.sv
// Self-checking testbench for the PWM prescaler and TOP solver: stream requests, APB clock register.
module tb_pwm_prescaler_top_duty_solver;

   localparam int STALL_LIMIT = 4000;
   localparam int PRINT_CAP   = 40;
   localparam int DRAIN_WAIT  = 250;

   // register byte addresses: index 0 is clock_hz, index 1 does not exist
   localparam logic [pwmps_pkg::CSR_ADDR_W-1:0] CSR_ADDR_CLOCK  = 3'd0;
   localparam logic [pwmps_pkg::CSR_ADDR_W-1:0] CSR_ADDR_UNUSED = 3'd4;

   localparam logic [pwmps_pkg::CLK_W-1:0] CLOCK_MIN = 26'd1000000;
   localparam logic [pwmps_pkg::CLK_W-1:0] CLOCK_MAX = 26'd50000000;

   typedef struct packed {
      pwmps_pkg::status_type            status;
      logic [pwmps_pkg::SEL_W-1:0]      sel;
      logic [pwmps_pkg::TOP_W-1:0]      top;
      logic [pwmps_pkg::TOP_W-1:0]      cmp;
   } pwm_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   // [2:0] channel, [26:3] freq_hz, [34:27] duty_percent, [39:35] zero
   logic [pwmps_pkg::REQ_DATA_W-1:0]    req_tdata = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   // [1:0] status, [4:2] clock_select, [20:5] top_value, [36:21] compare_value, [39:37] zero
   logic [pwmps_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [pwmps_pkg::CSR_ADDR_W-1:0]    csr_paddr = '0;
   logic [pwmps_pkg::CSR_DATA_W-1:0]    csr_pwdata = '0;
   logic [pwmps_pkg::CSR_DATA_W-1:0]    csr_prdata;
   logic                                csr_pready;

   pwm_prescaler_top_duty_solver dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // model copy of the register and the results still owed by the block
   logic [pwmps_pkg::CLK_W-1:0] clock_cfg = pwmps_pkg::CLOCK_RESET;
   pwm_result_type   pending_results[$];
   bit               idle_en = 1'b0;
   int               error_count = 0;
   int               req_count = 0;
   int               rsp_count = 0;
   int               ok_count = 0;
   int               clock_settings = 1;
   int               ready_hold = 0;
   int               quiet_cycles = 0;
   pwm_result_type   want;
   pwm_result_type   got;

   always #4 clock = ~clock;

   // prescaler ratio of table entry idx; the long table belongs to channels 4-5
   function automatic longint unsigned prescale_ratio(bit long_table, int idx);
      longint unsigned r;
      r = 1024;
      if (long_table) begin
         case (idx)
            0: r = 1;
            1: r = 8;
            2: r = 32;
            3: r = 64;
            4: r = 128;
            5: r = 256;
            default: r = 1024;
         endcase
      end else begin
         case (idx)
            0: r = 1;
            1: r = 8;
            2: r = 64;
            3: r = 256;
            default: r = 1024;
         endcase
      end
      return r;
   endfunction

   // prescaler walk, TOP and duty compare for one request
   function automatic pwm_result_type solve_prescaler(
         logic [pwmps_pkg::CHAN_W-1:0] ch,
         logic [pwmps_pkg::FREQ_W-1:0] f,
         logic [pwmps_pkg::DUTY_W-1:0] d,
         logic [pwmps_pkg::CLK_W-1:0]  clk);
      pwm_result_type  res;
      bit              long_table;
      bit              found;
      int              steps;
      int              idx;
      longint unsigned limit;
      longint unsigned quot;
      longint unsigned top;
      longint unsigned cmp;
      res.status = pwmps_pkg::ST_BAD_FREQ;
      res.sel    = '0;
      res.top    = '0;
      res.cmp    = '0;
      if (ch >= pwmps_pkg::CHANNEL_COUNT) begin
         res.status = pwmps_pkg::ST_BAD_CHANNEL;
         return res;
      end
      if (d > pwmps_pkg::DUTY_MAX) begin
         res.status = pwmps_pkg::ST_BAD_DUTY;
         return res;
      end
      if (f == 0)
         return res;
      long_table = (ch >= 4);
      steps      = long_table ? 7 : 5;
      limit      = (ch == 2 || ch == 3) ? 65535 : 255;
      found      = 1'b0;
      top        = 0;
      idx        = 0;
      // a zero quotient does not fit; keep walking
      while (!found && idx < steps) begin
         quot = longint'(clk) / (prescale_ratio(long_table, idx) * longint'(f));
         if (quot != 0 && quot - 1 <= limit) begin
            top     = quot - 1;
            res.sel = 3'(idx + 1);
            found   = 1'b1;
         end
         idx++;
      end
      // no fit, or first fit gives TOP of zero
      if (!found || top == 0) begin
         res.sel = '0;
         return res;
      end
      cmp = (longint'(d) * (top + 1)) / 100;
      if (cmp > 0)
         cmp = cmp - 1;
      res.status = pwmps_pkg::ST_OK;
      res.top    = top[pwmps_pkg::TOP_W-1:0];
      res.cmp    = cmp[pwmps_pkg::TOP_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, longint unsigned exp_val,
                                  longint unsigned got_val);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("mismatch %0s at result %0d: expected 0x%0h got 0x%0h",
                  what, rsp_count, exp_val, got_val);
   endtask

   // one request beat; the expected result is queued when the beat is taken
   task automatic send_req(logic [pwmps_pkg::CHAN_W-1:0] ch,
                           logic [pwmps_pkg::FREQ_W-1:0] f,
                           logic [pwmps_pkg::DUTY_W-1:0] d);
      int gap;
      gap = idle_en ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, d, f, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(solve_prescaler(ch, f, d, clock_cfg));
      req_count++;
   endtask

   // mostly requests aimed at a fitting TOP, some with raw fields
   task automatic send_random_req();
      logic [pwmps_pkg::CHAN_W-1:0] ch;
      logic [pwmps_pkg::FREQ_W-1:0] f;
      logic [pwmps_pkg::DUTY_W-1:0] d;
      int                kind;
      longint unsigned   span;
      longint unsigned   target;
      kind = $urandom_range(0, 9);
      ch   = (kind == 0) ? 3'($urandom_range(0, 7))
                         : 3'($urandom_range(0, pwmps_pkg::CHANNEL_COUNT - 1));
      d    = (kind == 1) ? 8'($urandom) : 8'($urandom_range(0, 100));
      if (kind == 2) begin
         f = 24'($urandom);
      end else if (kind == 3) begin
         f = 24'($urandom_range(0, 3));
      end else begin
         span = prescale_ratio(1'b1, $urandom_range(0, 6)) *
                (($urandom_range(0, 1) != 0) ? $urandom_range(1, 300)
                                             : $urandom_range(1, 70000));
         target = longint'(clock_cfg) / span;
         if (target == 0)
            target = $urandom_range(1, 16);
         if (target > 24'hFFFFFF)
            target = 24'hFFFFFF;
         f = target[pwmps_pkg::FREQ_W-1:0];
      end
      send_req(ch, f, d);
   endtask

   // stop sending and wait for every owed result
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // APB write, then a read-back of clock_hz in a back-to-back transfer
   task automatic write_reg(logic [pwmps_pkg::CSR_ADDR_W-1:0] addr,
                            logic [pwmps_pkg::CSR_DATA_W-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == CSR_ADDR_CLOCK)
         clock_cfg = val[pwmps_pkg::CLK_W-1:0];
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_CLOCK;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {{(pwmps_pkg::CSR_DATA_W-pwmps_pkg::CLK_W){1'b0}}, clock_cfg})
         report_mismatch("clock_hz read-back", clock_cfg, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // rejections and their priority: channel, then duty, then frequency
   task automatic test_reject_order();
      idle_en = 1'b0;
      send_req(3'd6, 24'd1000, 8'd50);
      send_req(3'd7, 24'd0, 8'd255);
      send_req(3'd0, 24'd1000, 8'd101);
      send_req(3'd3, 24'd0, 8'd255);
      send_req(3'd2, 24'd0, 8'd50);
      send_req(3'd5, 24'hFFFFFF, 8'd0);
      drain();
   endtask

   // fit boundaries at the reset clock: TOP zero, no fit, limits of each group
   task automatic test_fit_edges();
      idle_en = 1'b1;
      send_req(3'd0, 24'd62500, 8'd50);
      send_req(3'd1, 24'd8000000, 8'd100);
      send_req(3'd0, 24'd16000000, 8'd50);
      send_req(3'd1, 24'hFFFFFF, 8'd50);
      send_req(3'd0, 24'd1, 8'd50);
      send_req(3'd2, 24'd1, 8'd50);
      send_req(3'd4, 24'd1, 8'd50);
      send_req(3'd5, 24'd500, 8'd75);
      send_req(3'd1, 24'd1000, 8'd0);
      send_req(3'd3, 24'd1000, 8'd100);
      send_req(3'd4, 24'd61, 8'd100);
      send_req(3'd2, 24'd245, 8'd1);
      send_req(3'd3, 24'd244, 8'd99);
      send_req(3'd4, 24'd10000000, 8'd50);
      send_req(3'd5, 24'd62500, 8'd100);
      drain();
   endtask

   // random traffic under several clock settings, extremes included
   task automatic test_clock_sweep();
      logic [pwmps_pkg::CLK_W-1:0] settings[8];
      int               k;
      int               n;
      settings[0] = pwmps_pkg::CLOCK_RESET;
      settings[1] = CLOCK_MIN;
      settings[2] = CLOCK_MAX;
      settings[3] = '0;
      settings[4] = '1;
      settings[5] = 26'($urandom_range(CLOCK_MIN, CLOCK_MAX));
      settings[6] = 26'($urandom_range(CLOCK_MIN, CLOCK_MAX));
      settings[7] = pwmps_pkg::CLOCK_RESET;
      for (k = 0; k < 8; k++) begin
         if (k != 0) begin
            write_reg(CSR_ADDR_CLOCK,
                      {{(pwmps_pkg::CSR_DATA_W-pwmps_pkg::CLK_W){1'b0}}, settings[k]});
            clock_settings++;
         end
         idle_en = (k % 3 != 2);
         for (n = 0; n < ((settings[k] == 0) ? 50 : 230); n++)
            send_random_req();
         drain();
      end
   endtask

   // a write beyond the only register must leave clock_hz alone
   task automatic test_ignored_index();
      int n;
      write_reg(CSR_ADDR_UNUSED, $urandom);
      idle_en = 1'b1;
      for (n = 0; n < 20; n++)
         send_random_req();
      drain();
   endtask

   // result side: random stall after each accepted beat
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         ready_hold = idle_en ? $urandom_range(0, 3) : 0;
         if (ready_hold != 0)
            rsp_tready <= 1'b0;
      end else if (ready_hold != 0) begin
         ready_hold = ready_hold - 1;
         if (ready_hold == 0)
            rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         got.status = pwmps_pkg::status_type'(rsp_tdata[1:0]);
         got.sel    = rsp_tdata[4:2];
         got.top    = rsp_tdata[20:5];
         got.cmp    = rsp_tdata[36:21];
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 0, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            if (got.status != want.status)
               report_mismatch("status", want.status, got.status);
            if (got.sel != want.sel)
               report_mismatch("clock_select", want.sel, got.sel);
            if (got.top != want.top)
               report_mismatch("top_value", want.top, got.top);
            if (got.cmp != want.cmp)
               report_mismatch("compare_value", want.cmp, got.cmp);
            if (want.status == pwmps_pkg::ST_OK)
               ok_count++;
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", quiet_cycles);
            $display("tb_pwm_prescaler_top_duty_solver failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reject_order();
      test_fit_edges();
      test_clock_sweep();
      test_ignored_index();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never delivered", pending_results.size(), 0);
      $display("covered %0d requests and %0d results (%0d solved) over %0d clock settings",
               req_count, rsp_count, ok_count, clock_settings);
      $display("with rejects, fit edges, zero and full-scale clocks and an ignored register");
      if (error_count == 0) begin
         $display("tb_pwm_prescaler_top_duty_solver passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("tb_pwm_prescaler_top_duty_solver failed");
      end
      $finish;
   end

endmodule
